>>> src/oah_pkg.sv
package oah_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int VALUE_W    = 31;
  localparam int SLOT_W     = 8;
  localparam int MODE_W     = 2;
  localparam int SIZE_REG_W = 9;
  localparam int LFSR_W     = 16;
  localparam int STEP_W     = 5;
  localparam int DATA_W     = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [LFSR_W-1:0]     LFSR_RESET = 16'hACE1;
  localparam logic [LFSR_W-1:0]     LFSR_TAPS  = 16'hB400;
  localparam logic [SIZE_REG_W-1:0] SIZE_RESET = 9'd256;

  localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUADRATIC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RANDOM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // register index is paddr[2]
  localparam logic REG_PROBE_MODE = 1'b0;
  localparam logic REG_TABLE_SIZE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_READ,
    ST_CHECK,
    ST_RAND,
    ST_FINISH
  } state_t;

  function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage

>>> src/open_address_hash_probe_core.sv
// Open-addressing hash table: insert or search one 31-bit value per word.
// Input channel (in_valid/in_ready): operation and value. Output channel
// (out_valid/out_ready): success and slot, exactly one result per input word.
// Configuration goes through the APB port: probe_mode at 0x0, table_size at
// 0x4; write only while the core is idle.
// Steps per word: accept, then the home slot (value mod size, restoring
// remainder unit, one bit a cycle), then per probe a slot memory read,
// then a compare. In random mode every probe after the first adds another
// remainder pass, since the same remainder unit reduces home+lfsr.
// The probe budget is size probes for linear and for quadratic insert, and
// 2*size for quadratic search and for random. A finish step then hands
// the result to the output register. in_ready is high only while idle.
// Reset: the slot memory is swept empty, one slot per cycle, over all
// TABLE_DEPTH slots; in_ready stays low during the sweep, APB writes are taken.
// When the receiver stalls, a held result stays in the output register; the
// next word may be accepted and worked, and its result waits until taken.
module open_address_hash_probe_core #(
  parameter int TABLE_DEPTH = oah_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic [oah_pkg::VALUE_W-1:0]       value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              success,
  output logic [oah_pkg::SLOT_W-1:0]        slot,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [oah_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [oah_pkg::DATA_W-1:0]        pwdata,
  output logic [oah_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int IW  = $clog2(TABLE_DEPTH);
  localparam int SW  = $clog2(TABLE_DEPTH + 1);
  localparam int BW  = SW + 1;
  localparam int CW  = (SW > oah_pkg::SIZE_REG_W) ? SW : oah_pkg::SIZE_REG_W;
  localparam int RW  = ((IW > oah_pkg::LFSR_W) ? IW : oah_pkg::LFSR_W) + 1;
  localparam int MW  = oah_pkg::VALUE_W + 1;
  localparam int VW  = oah_pkg::VALUE_W;

  // configuration
  logic [oah_pkg::MODE_W-1:0]     probe_mode;
  logic [oah_pkg::SIZE_REG_W-1:0] table_size;

  // control
  oah_pkg::state_t state, state_next;
  logic [IW-1:0]   clear_addr;

  // item
  logic                       op;
  logic [VW-1:0]              val;
  logic [IW-1:0]              home;
  logic [IW-1:0]              idx, idx_next;
  logic [IW-1:0]              delta, delta_next;
  logic [BW-1:0]              count;
  logic [oah_pkg::LFSR_W-1:0] lfsr, lfsr_next;
  logic                       res_hit, res_hit_next;

  // remainder unit
  logic [IW-1:0]              rem;
  logic [VW-1:0]              dvd, dvd_next;
  logic [oah_pkg::STEP_W-1:0] steps, steps_next;
  logic [IW:0]                rem_try;
  logic [IW-1:0]              rem_step;
  logic                       div_done;

  // slot memory: bit MW-1 is the used flag
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rd_data;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  logic [CW-1:0] ts_w;
  logic [SW-1:0] eff;
  logic [IW:0]   eff_x;
  logic [BW-1:0] budget;
  logic [BW-1:0] cnt_inc;
  logic          probe_hit;
  logic          probe_last;
  logic [IW:0]   lin_sum, quad_sum, d2;
  logic [IW-1:0] lin_idx, quad_idx, delta_adv;
  logic [RW-1:0] rand_sum;
  logic          in_fire, out_load, cfg_we;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_mode <= oah_pkg::MODE_LINEAR;
      table_size <= oah_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        oah_pkg::REG_PROBE_MODE: probe_mode <= pwdata[oah_pkg::MODE_W-1:0];
        oah_pkg::REG_TABLE_SIZE: table_size <= pwdata[oah_pkg::SIZE_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      oah_pkg::REG_PROBE_MODE: prdata = oah_pkg::DATA_W'(probe_mode);
      oah_pkg::REG_TABLE_SIZE: prdata = oah_pkg::DATA_W'(table_size);
      default:                 prdata = '0;
    endcase
  end

  // ---------------- size and budget ----------------
  assign ts_w = CW'(table_size);

  always_comb begin
    priority if (table_size == '0) begin
      eff = SW'(1);
    end else if (ts_w > CW'(TABLE_DEPTH)) begin
      eff = SW'(TABLE_DEPTH);
    end else begin
      eff = SW'(ts_w);
    end
  end

  assign eff_x = (IW + 1)'(eff);

  always_comb begin
    unique case (probe_mode)
      oah_pkg::MODE_LINEAR:    budget = BW'(eff);
      oah_pkg::MODE_QUADRATIC: budget = (op == oah_pkg::OP_SEARCH) ? (BW'(eff) << 1)
                                                                    : BW'(eff);
      oah_pkg::MODE_RANDOM:    budget = BW'(eff) << 1;
      default:                 budget = '0;
    endcase
  end

  // ---------------- remainder step ----------------
  assign rem_try  = {rem, dvd[VW-1]};
  assign rem_step = (rem_try >= eff_x) ? IW'(rem_try - eff_x) : IW'(rem_try);
  assign div_done = (steps == oah_pkg::STEP_W'(1));

  // ---------------- probe step ----------------
  assign probe_hit = (op == oah_pkg::OP_SEARCH)
                   ? (rd_data[MW-1] && (rd_data[VW-1:0] == val))
                   : !rd_data[MW-1];
  assign cnt_inc    = count + BW'(1);
  assign probe_last = (cnt_inc == budget);

  assign lin_sum  = (IW + 1)'(idx) + (IW + 1)'(1);
  assign lin_idx  = (lin_sum >= eff_x) ? '0 : IW'(lin_sum);
  assign quad_sum = (IW + 1)'(idx) + (IW + 1)'(delta);
  assign quad_idx = (quad_sum >= eff_x) ? IW'(quad_sum - eff_x) : IW'(quad_sum);
  assign d2       = (IW + 1)'(delta) + (IW + 1)'(2);

  always_comb begin
    priority if (eff == SW'(1)) begin
      delta_adv = '0;
    end else if (d2 >= eff_x) begin
      delta_adv = IW'(d2 - eff_x);
    end else begin
      delta_adv = IW'(d2);
    end
  end

  assign rand_sum = RW'(home) + RW'(lfsr);

  // ---------------- handshakes ----------------
  assign in_ready = (state == oah_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == oah_pkg::ST_FINISH) && (!out_valid || out_ready);

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      oah_pkg::ST_CLEAR: begin
        if (clear_addr == IW'(TABLE_DEPTH - 1)) begin
          state_next = oah_pkg::ST_IDLE;
        end
      end
      oah_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = oah_pkg::ST_HOME;
        end
      end
      oah_pkg::ST_HOME: begin
        if (div_done) begin
          state_next = (budget == '0) ? oah_pkg::ST_FINISH : oah_pkg::ST_READ;
        end
      end
      oah_pkg::ST_READ: state_next = oah_pkg::ST_CHECK;
      oah_pkg::ST_CHECK: begin
        priority if (probe_hit || probe_last) begin
          state_next = oah_pkg::ST_FINISH;
        end else if (probe_mode == oah_pkg::MODE_RANDOM) begin
          state_next = oah_pkg::ST_RAND;
        end else begin
          state_next = oah_pkg::ST_READ;
        end
      end
      oah_pkg::ST_RAND: begin
        if (div_done) begin
          state_next = oah_pkg::ST_READ;
        end
      end
      oah_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = oah_pkg::ST_IDLE;
        end
      end
      default: state_next = oah_pkg::ST_IDLE;
    endcase
  end

  // ---------------- datapath next values ----------------
  always_comb begin
    idx_next     = idx;
    delta_next   = delta;
    lfsr_next    = lfsr;
    res_hit_next = res_hit;
    dvd_next     = dvd;
    steps_next   = steps;
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = {1'b1, val};
    unique case (state)
      oah_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = '0;
      end
      oah_pkg::ST_IDLE: begin
        dvd_next     = value;
        steps_next   = oah_pkg::STEP_W'(VW);
        res_hit_next = 1'b0;
        delta_next   = (eff == SW'(1)) ? '0 : IW'(1);
      end
      oah_pkg::ST_HOME, oah_pkg::ST_RAND: begin
        dvd_next   = dvd << 1;
        steps_next = steps - oah_pkg::STEP_W'(1);
        if (div_done) begin
          idx_next = rem_step;
        end
      end
      oah_pkg::ST_READ: ;
      oah_pkg::ST_CHECK: begin
        if (probe_hit) begin
          res_hit_next = 1'b1;
          mem_we       = (op == oah_pkg::OP_INSERT);
        end else begin
          unique case (probe_mode)
            oah_pkg::MODE_LINEAR: idx_next = lin_idx;
            oah_pkg::MODE_QUADRATIC: begin
              idx_next   = quad_idx;
              delta_next = delta_adv;
            end
            oah_pkg::MODE_RANDOM: begin
              lfsr_next  = oah_pkg::lfsr_advance(lfsr);
              dvd_next   = VW'(rand_sum) << (VW - RW);
              steps_next = oah_pkg::STEP_W'(RW);
            end
            default: ;
          endcase
        end
      end
      oah_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= oah_pkg::ST_CLEAR;
      clear_addr <= '0;
      lfsr       <= oah_pkg::LFSR_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      lfsr  <= lfsr_next;
      if (state == oah_pkg::ST_CLEAR) begin
        clear_addr <= clear_addr + IW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op  <= operation;
      val <= value;
    end
    if (state == oah_pkg::ST_IDLE) begin
      rem   <= '0;
      count <= '0;
    end else if (state == oah_pkg::ST_HOME || state == oah_pkg::ST_RAND) begin
      rem <= div_done ? '0 : rem_step;
    end else if (state == oah_pkg::ST_CHECK) begin
      count <= cnt_inc;
    end
    if (state == oah_pkg::ST_HOME && div_done) begin
      home <= rem_step;
    end
    idx     <= idx_next;
    delta   <= delta_next;
    res_hit <= res_hit_next;
    dvd     <= dvd_next;
    steps   <= steps_next;
    if (out_load) begin
      success <= res_hit;
      slot    <= res_hit ? oah_pkg::SLOT_W'(idx) : '0;
    end
  end

  // ---------------- slot memory ----------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == oah_pkg::ST_READ) begin
      rd_data <= mem[idx];
    end
  end

endmodule
